### hdl/range_max_query_engine_top_assert.svh
// assertion macros for the range max query engine
`ifndef RANGE_MAX_QUERY_ENGINE_TOP_ASSERT_SVH
`define RANGE_MAX_QUERY_ENGINE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define RMQ_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define RMQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define RMQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RMQ_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define RMQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define RMQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### hdl/rmq_pkg.sv
`default_nettype none

package rmq_pkg;

    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int BLOCK_SIZE_DEF   = 30;
    localparam int TABLE_DEPTH_DEF  = 256;

    localparam int CMD_W = 2;
    localparam int VAL_W = 64;
    localparam int IDX_W = 10;

    typedef logic [CMD_W-1:0] t_cmd;
    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic [IDX_W-1:0] t_idx;

    localparam t_cmd CMD_APPEND = 2'd0;
    localparam t_cmd CMD_QUERY  = 2'd1;
    localparam t_cmd CMD_CLEAR  = 2'd2;

endpackage

`default_nettype wire

### hdl/rmq_cmd_if.sv
`default_nettype none

interface rmq_cmd_if;
    import rmq_pkg::*;

    logic valid;
    logic ready;
    t_cmd command;
    t_val load_value;
    t_idx left_index;
    t_idx right_index;

    modport source (output valid, command, load_value, left_index, right_index,
                    input ready);
    modport sink (input valid, command, load_value, left_index, right_index,
                  output ready);
endinterface

`default_nettype wire

### hdl/rmq_rsp_if.sv
`default_nettype none

interface rmq_rsp_if;
    import rmq_pkg::*;

    logic valid;
    logic ready;
    t_val max_value;
    logic range_error;

    modport source (output valid, max_value, range_error, input ready);
    modport sink (input valid, max_value, range_error, output ready);
endinterface

`default_nettype wire

### hdl/rmq_ram.sv
`default_nettype none

module rmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

### hdl/range_max_query_engine_top.sv
// range max query engine
// i_cmd carries one word per command: append a signed 64-bit value, query an
// inclusive index range, or clear the store. o_rsp carries one word per query:
// the largest value in range, or range_error with a zero value.
// the block takes a command only when its sequencer is idle; one signed
// comparator and three single-port-read memories (values, per-element stack
// masks, sparse table of block maxima) are stepped by the sequencer.
// append: the scan compares and pops stack entries until a kept entry
// stops it or the stack is empty.
// clear and unused codes take no further steps; a bad query goes straight
// to the result.
// query of up to BLOCK_SIZE elements: mask read, then value read.
// longer query: a chain of mask, table and value reads, with the table reads
// only when whole blocks lie between the left and right edge windows.
// the first long query after a stored append or a clear first rebuilds the table:
// a pass over the blocks, then one over the table entries of each higher level.
// a finished result sits in an output register; a new command is taken while
// it waits, but the next result holds the sequencer until the receiver takes
// the earlier one.
// reset empties the store at once: no memory clearing pass is needed.
`default_nettype none

`include "range_max_query_engine_top_assert.svh"

module range_max_query_engine_top #(
    parameter int MAX_ELEMENTS = rmq_pkg::MAX_ELEMENTS_DEF,
    parameter int BLOCK_SIZE   = rmq_pkg::BLOCK_SIZE_DEF,
    parameter int TABLE_DEPTH  = rmq_pkg::TABLE_DEPTH_DEF
) (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    rmq_cmd_if.sink   i_cmd,
    rmq_rsp_if.source o_rsp
);
    import rmq_pkg::*;

    localparam int IW  = $clog2(MAX_ELEMENTS);
    localparam int CW  = $clog2(MAX_ELEMENTS + 1);
    localparam int XW  = $clog2(MAX_ELEMENTS + BLOCK_SIZE);
    localparam int BW  = $clog2(BLOCK_SIZE);
    localparam int NBW = $clog2(MAX_ELEMENTS / BLOCK_SIZE + 1);
    localparam int JW  = $clog2(IW);
    localparam int KW  = NBW + JW + 1;
    localparam int TAW = $clog2(TABLE_DEPTH);
    localparam int DSH  = IW + BW;
    localparam int DMUL = (2 ** DSH + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam int PW   = 2 * IW + 2;

    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_APP_CHK = 5'd1;
    localparam logic [4:0] ST_APP_CMP = 5'd2;
    localparam logic [4:0] ST_APP_FIN = 5'd3;
    localparam logic [4:0] ST_SQ_M    = 5'd4;
    localparam logic [4:0] ST_SQ_V    = 5'd5;
    localparam logic [4:0] ST_SQ_R    = 5'd6;
    localparam logic [4:0] ST_DIV     = 5'd7;
    localparam logic [4:0] ST_B1_RD   = 5'd8;
    localparam logic [4:0] ST_B1_WR   = 5'd9;
    localparam logic [4:0] ST_B2_CHK  = 5'd10;
    localparam logic [4:0] ST_B2_A    = 5'd11;
    localparam logic [4:0] ST_B2_B    = 5'd12;
    localparam logic [4:0] ST_B2_W    = 5'd13;
    localparam logic [4:0] ST_L_A     = 5'd14;
    localparam logic [4:0] ST_L_B     = 5'd15;
    localparam logic [4:0] ST_L_C     = 5'd16;
    localparam logic [4:0] ST_L_D     = 5'd17;
    localparam logic [4:0] ST_L_E     = 5'd18;
    localparam logic [4:0] ST_L_J     = 5'd19;
    localparam logic [4:0] ST_L_K     = 5'd20;
    localparam logic [4:0] ST_L_T1    = 5'd21;
    localparam logic [4:0] ST_L_T2    = 5'd22;
    localparam logic [4:0] ST_L_T3    = 5'd23;
    localparam logic [4:0] ST_L_T4    = 5'd24;
    localparam logic [4:0] ST_DONE    = 5'd25;

    function automatic logic [BW-1:0] f_top(input logic [BLOCK_SIZE-1:0] m);
        logic [BW-1:0] p;
        p = '0;
        for (int k = 0; k < BLOCK_SIZE; k++) begin
            if (m[k]) p = BW'(k);
        end
        return p;
    endfunction

    function automatic logic [BW-1:0] f_low(input logic [BLOCK_SIZE-1:0] m);
        logic [BW-1:0] p;
        p = '0;
        for (int k = BLOCK_SIZE - 1; k >= 0; k--) begin
            if (m[k]) p = BW'(k);
        end
        return p;
    endfunction

    function automatic logic [JW-1:0] f_top_idx(input logic [IW-1:0] m);
        logic [JW-1:0] p;
        p = '0;
        for (int k = 0; k < IW; k++) begin
            if (m[k]) p = JW'(k);
        end
        return p;
    endfunction

    function automatic logic [BLOCK_SIZE-1:0] f_window(input logic [IW:0] len);
        logic [BLOCK_SIZE-1:0] w;
        for (int k = 0; k < BLOCK_SIZE; k++) begin
            w[k] = (32'(len) > k);
        end
        return w;
    endfunction

    logic [4:0]            r_state;
    logic [CW-1:0]         r_count;
    logic [NBW-1:0]        r_nb;
    logic [BW-1:0]         r_brem;
    logic                  r_table_cur;
    logic [BLOCK_SIZE-1:0] r_stack;
    logic [BLOCK_SIZE-1:0] r_at;
    logic signed [VAL_W-1:0] r_hold;
    logic [IW-1:0]         r_l;
    logic [IW-1:0]         r_r;
    logic                  r_err;
    logic [IW-1:0]         r_dl;
    logic [IW-1:0]         r_dr;
    logic [NBW-1:0]        r_i;
    logic [XW-1:0]         r_maddr;
    logic [KW-1:0]         r_half;
    logic [KW-1:0]         r_pbase;
    logic [KW-1:0]         r_base;
    logic [IW-1:0]         r_ia;
    logic [IW-1:0]         r_ib;
    logic                  r_oob;
    logic [JW-1:0]         r_j;
    logic [KW-1:0]         r_k1;
    logic [KW-1:0]         r_k2;
    logic                  r_ov;
    logic signed [VAL_W-1:0] r_omax;
    logic                  r_oerr;

    logic                  v_we;
    logic [IW-1:0]         v_waddr;
    logic [IW-1:0]         v_raddr;
    logic signed [VAL_W-1:0] v_rdata;
    logic                  m_we;
    logic [BLOCK_SIZE-1:0] m_rdata;
    logic [IW-1:0]         m_raddr;
    logic                  t_we;
    logic [TAW-1:0]        t_waddr;
    logic [IW-1:0]         t_wdata;
    logic [TAW-1:0]        t_raddr;
    logic [IW-1:0]         t_rdata;

    logic                  accept;
    logic                  out_free;
    logic                  done_fire;
    logic                  gt;
    logic [IW-1:0]         t_idx_rd;
    logic [IW-1:0]         app_j;
    logic [IW-1:0]         sq_ans;
    logic [IW-1:0]         win_full;
    logic [KW-1:0]         b2_ra;
    logic [KW-1:0]         b2_rb;
    logic [KW-1:0]         b2_w;
    logic [PW-1:0]         div_l;
    logic [PW-1:0]         div_r;
    logic [KW-1:0]         nbj;

    assign accept    = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == ST_IDLE);
    assign out_free  = !r_ov || o_rsp.ready;
    assign done_fire = (r_state == ST_DONE) && out_free;
    assign o_rsp.valid       = r_ov;
    assign o_rsp.max_value   = r_omax;
    assign o_rsp.range_error = r_oerr;

    // the one shared comparator: held value against memory read data
    assign gt = r_hold > v_rdata;

    assign t_idx_rd = r_oob ? '0 : t_rdata;
    assign app_j    = r_ia - IW'(f_low(r_at));
    assign sq_ans   = r_r - IW'(f_top(m_rdata & f_window((IW+1)'(r_r - r_l) + 1'b1)));
    assign win_full = IW'(r_maddr) - IW'(f_top(m_rdata));
    assign b2_ra    = r_pbase + KW'(r_i);
    assign b2_rb    = r_pbase + KW'(r_i) + r_half;
    assign b2_w     = r_base + KW'(r_i);
    // block number by reciprocal multiplication, exact over the index range
    assign div_l    = PW'(r_l) * PW'(DMUL);
    assign div_r    = PW'(r_r) * PW'(DMUL);
    assign nbj      = KW'(r_nb) * KW'(r_j);

    // memory port control
    always_comb begin
        v_we    = 1'b0;
        v_waddr = IW'(r_count);
        v_raddr = r_ia;
        m_we    = 1'b0;
        m_raddr = r_r;
        t_we    = 1'b0;
        t_waddr = TAW'(r_i);
        t_wdata = win_full;
        t_raddr = TAW'(b2_ra);
        unique case (r_state)
            ST_IDLE: begin
                v_we = accept && (i_cmd.command == CMD_APPEND) &&
                       (32'(r_count) < MAX_ELEMENTS);
            end
            ST_APP_CHK: v_raddr = app_j;
            ST_APP_FIN: m_we = 1'b1;
            ST_SQ_V:    v_raddr = sq_ans;
            ST_B1_RD:   m_raddr = IW'(r_maddr);
            ST_B1_WR:   t_we = (32'(r_i) < TABLE_DEPTH);
            ST_B2_CHK:  t_raddr = TAW'(b2_ra);
            ST_B2_A: begin
                t_raddr = TAW'(b2_rb);
                v_raddr = t_idx_rd;
            end
            ST_B2_B:    v_raddr = t_idx_rd;
            ST_B2_W: begin
                t_we    = (32'(b2_w) < TABLE_DEPTH);
                t_waddr = TAW'(b2_w);
                t_wdata = gt ? r_ia : r_ib;
            end
            ST_L_A:     m_raddr = r_l + IW'(BLOCK_SIZE - 1);
            ST_L_B:     m_raddr = r_r;
            ST_L_C:     v_raddr = r_ia;
            ST_L_D:     v_raddr = r_ib;
            ST_L_T1:    t_raddr = TAW'(r_k1);
            ST_L_T2: begin
                t_raddr = TAW'(r_k2);
                v_raddr = t_idx_rd;
            end
            ST_L_T3:    v_raddr = t_idx_rd;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_nb        <= '0;
            r_brem      <= '0;
            r_table_cur <= 1'b0;
            r_stack     <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_l    <= IW'(i_cmd.left_index);
                        r_r    <= IW'(i_cmd.right_index);
                        priority case (i_cmd.command)
                            CMD_APPEND: begin
                                if (32'(r_count) < MAX_ELEMENTS) begin
                                    r_hold  <= i_cmd.load_value;
                                    r_ia    <= IW'(r_count);
                                    r_at    <= {r_stack[BLOCK_SIZE-2:0], 1'b0};
                                    r_state <= ST_APP_CHK;
                                end
                            end
                            CMD_CLEAR: begin
                                r_count     <= '0;
                                r_nb        <= '0;
                                r_brem      <= '0;
                                r_stack     <= '0;
                                r_table_cur <= 1'b0;
                            end
                            CMD_QUERY: begin
                                if ((i_cmd.left_index > i_cmd.right_index) ||
                                    (32'(i_cmd.right_index) >= 32'(r_count))) begin
                                    r_err   <= 1'b1;
                                    r_hold  <= '0;
                                    r_state <= ST_DONE;
                                end else if (32'(i_cmd.right_index) -
                                             32'(i_cmd.left_index) < BLOCK_SIZE) begin
                                    r_err   <= 1'b0;
                                    r_state <= ST_SQ_M;
                                end else begin
                                    r_err   <= 1'b0;
                                    r_state <= ST_DIV;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_APP_CHK: begin
                    r_state <= (r_at == '0) ? ST_APP_FIN : ST_APP_CMP;
                end
                ST_APP_CMP: begin
                    // strictly greater new value pops the older stack entry
                    if (gt) begin
                        r_at    <= r_at & (r_at - 1'b1);
                        r_state <= ST_APP_CHK;
                    end else begin
                        r_state <= ST_APP_FIN;
                    end
                end
                ST_APP_FIN: begin
                    r_stack     <= r_at | BLOCK_SIZE'(1);
                    r_count     <= r_count + 1'b1;
                    r_table_cur <= 1'b0;
                    if (32'(r_brem) == BLOCK_SIZE - 1) begin
                        r_brem <= '0;
                        r_nb   <= r_nb + 1'b1;
                    end else begin
                        r_brem <= r_brem + 1'b1;
                    end
                    r_state <= ST_IDLE;
                end
                ST_SQ_M: r_state <= ST_SQ_V;
                ST_SQ_V: r_state <= ST_SQ_R;
                ST_SQ_R: begin
                    r_hold  <= v_rdata;
                    r_state <= ST_DONE;
                end
                ST_DIV: begin
                    r_dl    <= IW'(div_l >> DSH);
                    r_dr    <= IW'(div_r >> DSH);
                    r_i     <= '0;
                    r_maddr <= XW'(BLOCK_SIZE - 1);
                    r_state <= r_table_cur ? ST_L_A : ST_B1_RD;
                end
                ST_B1_RD: begin
                    if (r_i < r_nb) begin
                        r_state <= ST_B1_WR;
                    end else begin
                        r_i     <= '0;
                        r_half  <= KW'(1);
                        r_pbase <= '0;
                        r_base  <= KW'(r_nb);
                        r_state <= ST_B2_CHK;
                    end
                end
                ST_B1_WR: begin
                    r_i     <= r_i + 1'b1;
                    r_maddr <= r_maddr + XW'(BLOCK_SIZE);
                    r_state <= ST_B1_RD;
                end
                ST_B2_CHK: begin
                    if ((r_half << 1) > KW'(r_nb)) begin
                        r_table_cur <= 1'b1;
                        r_state     <= ST_L_A;
                    end else if (KW'(r_i) + (r_half << 1) <= KW'(r_nb)) begin
                        r_oob   <= (32'(b2_ra) >= TABLE_DEPTH);
                        r_state <= ST_B2_A;
                    end else begin
                        r_i     <= '0;
                        r_half  <= r_half << 1;
                        r_pbase <= r_base;
                        r_base  <= r_base + KW'(r_nb);
                    end
                end
                ST_B2_A: begin
                    r_ia    <= t_idx_rd;
                    r_oob   <= (32'(b2_rb) >= TABLE_DEPTH);
                    r_state <= ST_B2_B;
                end
                ST_B2_B: begin
                    r_ib    <= t_idx_rd;
                    r_hold  <= v_rdata;
                    r_state <= ST_B2_W;
                end
                ST_B2_W: begin
                    r_i     <= r_i + 1'b1;
                    r_state <= ST_B2_CHK;
                end
                ST_L_A: r_state <= ST_L_B;
                ST_L_B: begin
                    r_ia    <= r_l + IW'(BLOCK_SIZE - 1) - IW'(f_top(m_rdata));
                    r_state <= ST_L_C;
                end
                ST_L_C: begin
                    r_ib    <= r_r - IW'(f_top(m_rdata));
                    r_state <= ST_L_D;
                end
                ST_L_D: begin
                    r_hold  <= v_rdata;
                    r_state <= ST_L_E;
                end
                ST_L_E: begin
                    if (!gt) r_hold <= v_rdata;
                    // whole blocks lie between the left and right edge windows
                    r_state <= (32'(r_dl) + 2 <= 32'(r_dr)) ? ST_L_J : ST_DONE;
                end
                ST_L_J: begin
                    r_j     <= f_top_idx(r_dr - r_dl - IW'(1));
                    r_state <= ST_L_K;
                end
                ST_L_K: begin
                    r_k1    <= nbj + KW'(r_dl) + KW'(1);
                    r_k2    <= nbj + KW'(r_dr) - (KW'(1) << r_j);
                    r_state <= ST_L_T1;
                end
                ST_L_T1: begin
                    r_oob   <= (32'(r_k1) >= TABLE_DEPTH);
                    r_state <= ST_L_T2;
                end
                ST_L_T2: begin
                    r_oob   <= (32'(r_k2) >= TABLE_DEPTH);
                    r_state <= ST_L_T3;
                end
                ST_L_T3: begin
                    if (!gt) r_hold <= v_rdata;
                    r_state <= ST_L_T4;
                end
                ST_L_T4: begin
                    if (!gt) r_hold <= v_rdata;
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (done_fire) begin
            r_ov   <= 1'b1;
            r_omax <= r_hold;
            r_oerr <= r_err;
        end else if (o_rsp.ready) begin
            r_ov <= 1'b0;
        end
    end

    rmq_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ELEMENTS)) u_values (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (v_waddr),
        .i_wdata (i_cmd.load_value),
        .i_raddr (v_raddr),
        .o_rdata (v_rdata)
    );

    rmq_ram #(.WIDTH(BLOCK_SIZE), .DEPTH(MAX_ELEMENTS)) u_masks (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (r_ia),
        .i_wdata (r_at | BLOCK_SIZE'(1)),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    rmq_ram #(.WIDTH(IW), .DEPTH(TABLE_DEPTH)) u_table (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (t_waddr),
        .i_wdata (t_wdata),
        .i_raddr (t_raddr),
        .o_rdata (t_rdata)
    );

    `RMQ_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, 32'(r_count) <= MAX_ELEMENTS, "count past capacity")
    `RMQ_ASSERT_IMPL(a_err_zero, i_clk, i_rst_n, o_rsp.valid && o_rsp.range_error, o_rsp.max_value == '0, "error word with nonzero value")
    `RMQ_ASSERT_NEXT(a_clear, i_clk, i_rst_n, accept && (i_cmd.command == CMD_CLEAR), (r_count == '0) && !r_table_cur, "clear did not empty store")

endmodule

`default_nettype wire
